FILE: sv/asas_pkg.sv
// Shared types, constants and the output scaling function for the sample averager.
`default_nettype none
package asas_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 8;
  localparam int CNT_W       = 9;
  localparam int OUT_W       = 13;
  localparam int RAW_W       = 16;
  localparam int NOT_READY_BIT = 7;
  localparam int SCALE_SHIFT = 11;                 // multiply by 2048
  localparam logic [15:0] SCALE_DIV = 16'd32767;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    ST_ACC,
    ST_DIV,
    ST_OUT
  } back_state_t;

  // Divider status seen by the back end
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // mean * 2048 / 32767, truncated. With x = mean << 11, q = x >> 15 and
  // r = x mod 32768, x / 32767 = q + (q + r) / 32767, and q + r stays below
  // twice the divisor, so one compare gives the correction.
  function automatic logic [OUT_W-1:0] scale_mean(input logic [RAW_W-1:0] mean);
    logic [11:0] q;
    logic [15:0] r;
    logic [15:0] t;
    q = mean[RAW_W-1:4];
    r = {1'b0, mean[3:0], 11'b0};
    t = 16'(q) + r;
    scale_mean = 13'(q) + 13'(t >= SCALE_DIV);
  endfunction

endpackage
`default_nettype wire

FILE: sv/asas_front.sv
// Front end: checks each readout and forwards usable samples to the queue.
`default_nettype none
module asas_front
  import asas_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   push,
  input  wire logic [BYTE_W-1:0]      data_high,
  input  wire logic [BYTE_W-1:0]      data_low,
  input  wire logic [BYTE_W-1:0]      status_byte,
  input  wire logic                   q_full,
  output logic                        full,
  output logic                        enq,
  output logic [SAMPLE_BITS-1:0]      enq_data
);

  logic [RAW_W-1:0] raw;
  logic             keep;

  // Combine the bytes and trim to the sample width
  assign raw      = {data_high, data_low};
  assign enq_data = SAMPLE_BITS'(raw);

  // Drop readouts flagged not ready and zero readings
  assign keep = !status_byte[NOT_READY_BIT] && (enq_data != '0);

  assign full = q_full;
  assign enq  = push && !q_full && keep;

endmodule
`default_nettype wire

FILE: sv/asas_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module asas_queue #(
  parameter int WIDTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic                  rd_valid,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  q_full
);

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_wr;
  logic             do_rd;

  assign rd_valid = (count != 2'd0);
  assign q_full   = (count == 2'd2);
  assign rd_data  = entry[rd_ptr];
  assign do_wr    = wr_en && !q_full;
  assign do_rd    = rd_en && rd_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entry[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        count <= count + 2'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/asas_div.sv
// Restoring divider, one quotient bit per cycle, for sum / sample count.
`default_nettype none
module asas_div
  import asas_pkg::*;
#(
  parameter int N = 24
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [N-1:0]     dividend,
  input  wire logic [CNT_W-1:0] divisor,
  output logic [N-1:0]          quotient,
  output div_status_t           status
);

  localparam int STEP_W = $clog2(N + 1);

  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [N-1:0]      quo;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [CNT_W:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and test against the divisor
  assign trial = {rem, quo[N-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[N-2:0], fits};
      rem <= fits ? CNT_W'(trial - {1'b0, dvs}) : trial[CNT_W-1:0];
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        done <= 1'b0;
        step <= STEP_W'(N);
      end else if (busy) begin
        step <= step - STEP_W'(1);
        done <= (step == STEP_W'(1));
        if (step == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

FILE: sv/asas_back.sv
// Back end: accumulates samples, divides by the count, scales and holds the result.
`default_nettype none
module asas_back
  import asas_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [CFG_W-1:0]       average_count_minus_one,
  input  wire logic                   q_valid,
  input  wire logic [SAMPLE_BITS-1:0] q_data,
  output logic                        q_rd,
  input  wire logic                   pop,
  output logic                        empty,
  output logic [OUT_W-1:0]            averaged_value
);

  localparam int SUM_W = SAMPLE_BITS + 8;

  back_state_t       state;
  back_state_t       state_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  target;
  logic              close_blk;
  logic              div_start;
  logic [SUM_W-1:0]  quotient;
  div_status_t       div_st;
  logic              res_valid;
  logic              res_load;
  logic [OUT_W-1:0]  res_value;

  assign target    = CNT_W'(average_count_minus_one) + CNT_W'(1);
  assign sum_next  = sum + SUM_W'(q_data);
  assign cnt_next  = cnt + CNT_W'(1);
  assign close_blk = (cnt_next >= target);

  asas_div #(
    .N(SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (cnt_next),
    .quotient (quotient),
    .status   (div_st)
  );

  // Sequencer: next state and strobes
  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      ST_ACC: begin
        q_rd = 1'b1;
        if (q_valid && close_blk) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_st.done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!res_valid || pop) begin
          res_load   = 1'b1;
          state_next = ST_ACC;
        end
      end
      default: begin
        state_next = ST_ACC;
      end
    endcase
  end

  // State register, accumulator and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      sum       <= '0;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_ACC && q_valid) begin
        if (close_blk) begin
          sum <= '0;
          cnt <= '0;
        end else begin
          sum <= sum_next;
          cnt <= cnt_next;
        end
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result register; the mean never exceeds the raw 16-bit range
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_value <= scale_mean(quotient[RAW_W-1:0]);
    end
  end

  assign empty          = !res_valid;
  assign averaged_value = res_value;

`ifndef SYNTH
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && res_valid && !pop) |=> (state == ST_OUT && res_valid))
    else $error("pending quotient lost while result was stalled");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt < CNT_W'(256))
    else $error("sample count passed its limit");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ST_DIV))
    else $error("divider finished outside the divide state");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (div_st.busy && state == ST_DIV && cnt == '0))
    else $error("divider start did not take effect");
`endif

endmodule
`default_nettype wire

FILE: sv/adc_sample_average_scale_unit.sv
// Throughput: one sample per cycle while a block fills; closing a block runs the
//   bit-serial divider, then loads the result once the previous result is popped or none is held.
// The two-entry queue lets pushes continue while the back end divides or a result waits.
// Reset (rst, synchronous): clears the count register, sum, sample count, queue and result valid flag.
// Top level of the converter sample averager with 2048/32767 output scaling.
`default_nettype none
module adc_sample_average_scale_unit
  import asas_pkg::*;
#(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  // configuration
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_W-1:0]    cfg_data,
  // readouts
  input  wire logic                push,
  output logic                     full,
  input  wire logic [BYTE_W-1:0]   data_high,
  input  wire logic [BYTE_W-1:0]   data_low,
  input  wire logic [BYTE_W-1:0]   status_byte,
  // results
  output logic                     empty,
  input  wire logic                pop,
  output logic [OUT_W-1:0]         averaged_value
);

  logic [CFG_W-1:0]       average_count_minus_one;
  logic                   q_full;
  logic                   enq;
  logic [SAMPLE_BITS-1:0] enq_data;
  logic                   q_valid;
  logic [SAMPLE_BITS-1:0] q_data;
  logic                   q_rd;

  // Configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_count_minus_one <= '0;
    end else if (cfg_valid && cfg_ready) begin
      average_count_minus_one <= cfg_data;
    end
  end

  asas_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .push        (push),
    .data_high   (data_high),
    .data_low    (data_low),
    .status_byte (status_byte),
    .q_full      (q_full),
    .full        (full),
    .enq         (enq),
    .enq_data    (enq_data)
  );

  asas_queue #(
    .WIDTH(SAMPLE_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (enq),
    .wr_data  (enq_data),
    .rd_en    (q_rd),
    .rd_valid (q_valid),
    .rd_data  (q_data),
    .q_full   (q_full)
  );

  asas_back #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_back (
    .clk                     (clk),
    .rst                     (rst),
    .average_count_minus_one (average_count_minus_one),
    .q_valid                 (q_valid),
    .q_data                  (q_data),
    .q_rd                    (q_rd),
    .pop                     (pop),
    .empty                   (empty),
    .averaged_value          (averaged_value)
  );

endmodule
`default_nettype wire
